@@ hdl/rbcg_pkg.sv @@
// Shared types and constants for the rainbow blink colour generator.
package rbcg_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgBlinkHalf = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHueStep   = 2'd1;

  // Register reset values
  localparam logic [CfgDataW-1:0] BlinkHalfRst = 16'd250;
  localparam logic [CfgDataW-1:0] HueStepRst   = 16'd10;

  // Hue geometry
  localparam int unsigned HueW      = 9;
  localparam int unsigned DegFull   = 360;
  localparam int unsigned DegSector = 60;
  localparam logic [7:0]  FullOn    = 8'd255;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

@@ hdl/rbcg_color.sv @@
// Hue to full-saturation RGB conversion, black while dark.
module rbcg_color (
  input  logic [rbcg_pkg::HueW-1:0] hue_i,
  input  logic                      lit_i,
  output rbcg_pkg::rgb_t            rgb_o
);
  import rbcg_pkg::*;

  typedef enum logic [2:0] {
    SecRed, SecYellow, SecGreen, SecCyan, SecBlue, SecMagenta
  } sector_e;

  sector_e       sector;
  logic [HueW-1:0] base;
  logic [5:0]    rem;
  logic [9:0]    rem_x17;
  logic [7:0]    up;
  logic [7:0]    down;

  // Sector by threshold compares, remainder against the sector base
  always_comb begin
    if (hue_i >= HueW'(5 * DegSector)) begin
      sector = SecMagenta;
      base   = HueW'(5 * DegSector);
    end else if (hue_i >= HueW'(4 * DegSector)) begin
      sector = SecBlue;
      base   = HueW'(4 * DegSector);
    end else if (hue_i >= HueW'(3 * DegSector)) begin
      sector = SecCyan;
      base   = HueW'(3 * DegSector);
    end else if (hue_i >= HueW'(2 * DegSector)) begin
      sector = SecGreen;
      base   = HueW'(2 * DegSector);
    end else if (hue_i >= HueW'(DegSector)) begin
      sector = SecYellow;
      base   = HueW'(DegSector);
    end else begin
      sector = SecRed;
      base   = '0;
    end
  end

  assign rem = 6'(hue_i - base);

  // rem * 255 / 60 is exactly rem * 17 / 4, floored
  assign rem_x17 = {4'd0, rem} * 10'd17;
  assign up      = rem_x17[9:2];
  assign down    = FullOn - up;

  always_comb begin
    rgb_o = '0;
    if (lit_i) begin
      case (sector)
        SecRed:     rgb_o = '{red: FullOn, green: up,     blue: 8'd0};
        SecYellow:  rgb_o = '{red: down,   green: FullOn, blue: 8'd0};
        SecGreen:   rgb_o = '{red: 8'd0,   green: FullOn, blue: up};
        SecCyan:    rgb_o = '{red: 8'd0,   green: down,   blue: FullOn};
        SecBlue:    rgb_o = '{red: up,     green: 8'd0,   blue: FullOn};
        SecMagenta: rgb_o = '{red: FullOn, green: 8'd0,   blue: down};
        default:    rgb_o = '0;
      endcase
    end
  end

endmodule

@@ hdl/rainbow_blink_color_generator_unit.sv @@
// A tick is taken into the input register; its colour beat is held in the result register.
// Throughput: one tick per cycle unless a held result stalls the input; the blink and hue
// counters update in one pass between the input register and the result register.
// Reset: asynchronous, active low; the LED starts lit at hue zero, both periods
// return to 250 and 10 ticks, and the first tick always yields a beat.
// Configuration writes are taken every cycle.
module rainbow_blink_color_generator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_valid_i,
  output logic                          tick_stall_o,
  input  logic                          tick_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rbcg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rbcg_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic                          lit_o
);
  import rbcg_pkg::*;

  // Configuration registers
  logic [CfgDataW-1:0] blink_half_q, hue_step_q;

  // Input register
  logic in_valid_q, in_tick_q;

  // Timer state
  logic [CfgDataW-1:0] blink_cnt_q, blink_cnt_d;
  logic [CfgDataW-1:0] hue_cnt_q, hue_cnt_d;
  logic                lit_q, lit_d;
  logic [HueW-1:0]     hue_q, hue_d;
  logic [HueW-1:0]     prev_hue_q;
  logic                prev_lit_q;
  logic                primed_q;

  // Result register
  logic out_valid_q, out_valid_d;
  rgb_t out_rgb_q;
  logic out_lit_q;

  logic            advance, work, emit;
  logic [CfgDataW-1:0] blink_inc, hue_inc;
  logic [HueW:0]   hue_next;
  rgb_t            rgb;

  assign cfg_ready_o = 1'b1;

  // Pipeline advances whenever the result register is free or being drained
  assign advance      = !out_valid_q || !res_stall_i;
  assign tick_stall_o = in_valid_q && !advance;
  assign work         = in_valid_q && in_tick_q && advance;

  // Emission decision on the state held before this tick
  assign emit = !primed_q || (lit_q != prev_lit_q) || (lit_q && (hue_q != prev_hue_q));

  // Sub-counter updates
  assign blink_inc = blink_cnt_q + 16'd1;
  assign hue_inc   = hue_cnt_q + 16'd1;
  assign hue_next  = {1'b0, hue_q} + 10'd1;

  always_comb begin
    blink_cnt_d = blink_inc;
    lit_d       = lit_q;
    if (blink_inc >= blink_half_q) begin
      blink_cnt_d = '0;
      lit_d       = !lit_q;
    end
    hue_cnt_d = hue_inc;
    hue_d     = hue_q;
    if (hue_inc >= hue_step_q) begin
      hue_cnt_d = '0;
      hue_d     = (hue_next >= 10'(DegFull)) ? '0 : hue_next[HueW-1:0];
    end
  end

  rbcg_color u_color (
    .hue_i (hue_q),
    .lit_i (lit_q),
    .rgb_o (rgb)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = work && emit;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_half_q <= BlinkHalfRst;
      hue_step_q   <= HueStepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgBlinkHalf: blink_half_q <= cfg_data_i;
        CfgHueStep:   hue_step_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!tick_stall_o) begin
      in_valid_q <= tick_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!tick_stall_o) begin
      in_tick_q <= tick_i;
    end
  end

  // Timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_cnt_q <= '0;
      hue_cnt_q   <= '0;
      lit_q       <= 1'b1;
      hue_q       <= '0;
      prev_hue_q  <= '0;
      prev_lit_q  <= 1'b0;
      primed_q    <= 1'b0;
    end else if (work) begin
      blink_cnt_q <= blink_cnt_d;
      hue_cnt_q   <= hue_cnt_d;
      lit_q       <= lit_d;
      hue_q       <= hue_d;
      prev_hue_q  <= hue_q;
      prev_lit_q  <= lit_q;
      primed_q    <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work && emit) begin
      out_rgb_q <= rgb;
      out_lit_q <= lit_q;
    end
  end

  assign res_valid_o = out_valid_q;
  assign red_o       = out_rgb_q.red;
  assign green_o     = out_rgb_q.green;
  assign blue_o      = out_rgb_q.blue;
  assign lit_o       = out_lit_q;

  // Hue stays within one turn
  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hue_q < HueW'(DegFull))
    else $error("hue out of range");

  // A dark beat is black
  a_dark_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_lit_q) |-> (out_rgb_q == '0))
    else $error("dark beat carries colour");

  // A lit beat has one channel at full intensity
  a_lit_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_lit_q) |->
      (out_rgb_q.red == FullOn || out_rgb_q.green == FullOn || out_rgb_q.blue == FullOn))
    else $error("lit beat without a full channel");

  // Once primed, stays primed until reset
  a_primed_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    primed_q |=> primed_q)
    else $error("primed flag dropped");

  // Input side stalls only behind a held result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_stall_o |-> (out_valid_q && res_stall_i && in_valid_q))
    else $error("spurious input stall");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the rainbow blink colour generator unit.
`timescale 1ns / 1ps

module tb_top;
  import rbcg_pkg::*;

  // Indexes that address no register; writes to them must leave both periods alone
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  localparam int unsigned LiveTickTarget = 950;
  localparam int unsigned CycleLimit     = 400000;

  typedef struct packed {
    rgb_t rgb;
    logic lit;
  } colour_t;

  // Tracks blink phase and hue, and holds the colour beats still owed by the unit
  class colour_scoreboard;
    logic [CfgDataW-1:0] blink_half;
    logic [CfgDataW-1:0] hue_step;
    logic [15:0]         blink_cnt;
    logic [15:0]         hue_cnt;
    logic [HueW-1:0]     hue_deg;
    logic [HueW-1:0]     prev_hue;
    bit                  lit_now;
    bit                  prev_lit;
    bit                  primed;
    colour_t             pending_colours[$];
    int                  errors;

    function new();
      blink_half = BlinkHalfRst;
      hue_step   = HueStepRst;
      blink_cnt  = '0;
      hue_cnt    = '0;
      hue_deg    = '0;
      prev_hue   = '0;
      lit_now    = 1'b1;
      prev_lit   = 1'b0;
      primed     = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgBlinkHalf: blink_half = data;
        CfgHueStep:   hue_step   = data;
        default:      ;
      endcase
    endfunction

    // One accepted tick beat: decide on emission from the state held before the tick
    function void note_tick(logic tick);
      bit              on;
      bit              emit;
      logic [HueW-1:0] h;
      logic [7:0]      up;
      logic [7:0]      down;
      colour_t         c;
      if (tick !== 1'b1) return;
      on   = lit_now;
      h    = hue_deg;
      emit = !primed || (on != prev_lit) || (on && h != prev_hue);
      prev_hue = h;
      prev_lit = on;
      primed   = 1'b1;

      // both sub-counters advance; zero period behaves as one
      blink_cnt = blink_cnt + 16'd1;
      if (blink_cnt >= blink_half) begin
        blink_cnt = '0;
        lit_now   = !lit_now;
      end
      hue_cnt = hue_cnt + 16'd1;
      if (hue_cnt >= hue_step) begin
        hue_cnt = '0;
        hue_deg = (hue_deg + 1 >= DegFull) ? '0 : hue_deg + 9'd1;
      end
      if (!emit) return;

      // full-saturation hue wheel, black while dark
      c     = '0;
      c.lit = on;
      if (on) begin
        up   = 8'(((h % DegSector) * FullOn) / DegSector);
        down = FullOn - up;
        case (h / DegSector)
          0:       c.rgb = '{red: FullOn, green: up,     blue: 8'd0};
          1:       c.rgb = '{red: down,   green: FullOn, blue: 8'd0};
          2:       c.rgb = '{red: 8'd0,   green: FullOn, blue: up};
          3:       c.rgb = '{red: 8'd0,   green: down,   blue: FullOn};
          4:       c.rgb = '{red: up,     green: 8'd0,   blue: FullOn};
          default: c.rgb = '{red: FullOn, green: 8'd0,   blue: down};
        endcase
      end
      pending_colours.push_back(c);
    endfunction

    function void check_colour(colour_t got);
      colour_t want;
      if (pending_colours.size() == 0) begin
        if (errors < 10)
          $display("%0t: colour beat with none owed: r=%h g=%h b=%h lit=%b", $realtime,
                   got.rgb.red, got.rgb.green, got.rgb.blue, got.lit);
        errors++;
        return;
      end
      want = pending_colours.pop_front();
      if (got.rgb.red !== want.rgb.red || got.rgb.green !== want.rgb.green ||
          got.rgb.blue !== want.rgb.blue || got.lit !== want.lit) begin
        if (errors < 10)
          $display("%0t: colour mismatch: want r=%h g=%h b=%h lit=%b, got r=%h g=%h b=%h lit=%b",
                   $realtime, want.rgb.red, want.rgb.green, want.rgb.blue, want.lit,
                   got.rgb.red, got.rgb.green, got.rgb.blue, got.lit);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                tick_valid_i;
  logic                tick_stall_o;
  logic                tick_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                res_valid_o;
  logic                res_stall_i;
  logic [7:0]          red_o;
  logic [7:0]          green_o;
  logic [7:0]          blue_o;
  logic                lit_o;

  colour_scoreboard sb;
  int unsigned      ticks_taken = 0;
  int unsigned      live_ticks  = 0;
  int unsigned      cfgs_taken  = 0;
  int unsigned      cycles      = 0;
  int unsigned      sender_idle = 0;
  int unsigned      recv_idle   = 0;

  rainbow_blink_color_generator_unit DUT (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .tick_valid_i (tick_valid_i),
    .tick_stall_o (tick_stall_o),
    .tick_i       (tick_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .res_valid_o  (res_valid_o),
    .res_stall_i  (res_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .lit_o        (lit_o)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    res_stall_i <= ($urandom_range(0, 99) < recv_idle);
  end

  // Handshake monitor: results checked before the new tick is noted
  always @(posedge clk) begin
    if (rst_ni) begin
      if (res_valid_o && !res_stall_i)
        sb.check_colour({red_o, green_o, blue_o, lit_o});
      if (tick_valid_i && !tick_stall_o) begin
        ticks_taken++;
        if (tick_i) live_ticks++;
        sb.note_tick(tick_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cfgs_taken++;
        sb.write_reg(cfg_index_i, cfg_data_i);
      end
    end
  end

  // Send one tick beat; idling profile follows progress through the run
  task automatic send_tick(logic t);
    int unsigned taken_before;
    if (live_ticks < LiveTickTarget / 3) begin
      sender_idle = 25;
      recv_idle   = 66;
    end else if (live_ticks < 2 * LiveTickTarget / 3) begin
      sender_idle = 66;
      recv_idle   = 25;
    end else begin
      sender_idle = 0;
      recv_idle   = 0;
    end
    while ($urandom_range(0, 99) < sender_idle) begin
      tick_valid_i <= 1'b0;
      @(negedge clk);
    end
    taken_before = ticks_taken;
    tick_valid_i <= 1'b1;
    tick_i       <= t;
    do @(negedge clk); while (ticks_taken == taken_before);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    int unsigned taken_before;
    taken_before = cfgs_taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk); while (cfgs_taken == taken_before);
  endtask

  // Drain: wait until nothing is owed, then wait out a tick still in flight
  task automatic settle();
    tick_valid_i <= 1'b0;
    do @(negedge clk); while (sb.pending_colours.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(logic [CfgDataW-1:0] half, logic [CfgDataW-1:0] step, bit junk);
    settle();
    write_cfg(CfgBlinkHalf, half);
    if (junk) write_cfg($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, 16'($urandom));
    write_cfg(CfgHueStep, step);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CfgDataW-1:0] half;
    logic [CfgDataW-1:0] step;
    int unsigned         n;
    sb           = new();
    rst_ni       = 1'b0;
    tick_valid_i = 1'b0;
    tick_i       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Reset periods: an empty tick first, then the forced first beat
    send_tick(1'b0);
    repeat (4) send_tick(1'b1);

    // Writes to unused indexes ignored; fastest blink and hue
    settle();
    write_cfg(CfgSpareA, 16'hFFFF);
    write_cfg(CfgSpareB, 16'h0001);
    write_cfg(CfgBlinkHalf, 16'd1);
    write_cfg(CfgHueStep, 16'd1);
    cfg_valid_i <= 1'b0;
    repeat (6) send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    // Zero periods act as one
    configure(16'd0, 16'd0, 1'b0);
    repeat (4) send_tick(1'b1);

    // Longest periods, then lowered under the running counts
    configure(16'hFFFF, 16'hFFFF, 1'b0);
    repeat (4) send_tick(1'b1);
    configure(16'd2, 16'd3, 1'b0);
    repeat (4) send_tick(1'b1);

    // Random phases: mostly short periods so hue sweeps the wheel while blinking
    while (live_ticks < LiveTickTarget) begin
      case ($urandom_range(0, 9))
        0:       half = '0;
        1:       half = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(31, 65534));
        default: half = 16'($urandom_range(1, 30));
      endcase
      case ($urandom_range(0, 19))
        0, 1:                      step = '0;
        2, 3, 4, 5, 6, 7, 8, 9:    step = 16'd1;
        10, 11, 12, 13, 14, 15, 16: step = 16'($urandom_range(2, 5));
        17, 18:                    step = 16'($urandom_range(6, 60));
        default:                   step = 16'($urandom_range(61, 65535));
      endcase
      configure(half, step, $urandom_range(0, 3) == 0);
      n = (half > 1000 || step > 1000) ? $urandom_range(3, 10) : $urandom_range(15, 70);
      repeat (n) send_tick($urandom_range(0, 19) != 0);
    end

    settle();
    if (sb.errors == 0 && sb.pending_colours.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
